/* hdl/dh64_pkg.sv */
// dh64_pkg: shared constants and types for the 64-bit modular exponentiation block
// no dependencies
package dh64_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CELL_W  = 16;
    localparam int unsigned NCELLS  = WORD_W / CELL_W;
    localparam int unsigned CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] DH_PRIME     = 64'hffff_ffff_ffff_ffc5;
    localparam logic [WORD_W-1:0] DH_GEN_RESET = 64'd5;

    localparam logic OP_PUBLIC = 1'b0;
    localparam logic OP_SHARED = 1'b1;

    // control broadcast to every cell of the multiplier row
    typedef struct packed {
        logic load;    // acc <= 0, x <= operand slice
        logic run;     // one shift-and-add step
        logic add_en;  // current multiplier bit
        logic sel_a;   // acc + x reached the prime: take reduced value
        logic sel_x;   // x + x reached the prime: take reduced value
    } cell_ctl_t;

    // carries and borrows passed from a cell to its upper neighbor
    typedef struct packed {
        logic ca;
        logic ba;
        logic cx;
        logic bx;
    } cell_link_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SQR  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

/* hdl/dh64_modular_exponentiation.sv */
// dh64_modular_exponentiation: top level, square-and-multiply sequencer
// depends on dh64_pkg, dh64_mul
//
// Computes base^exponent mod 2^64-59, with the generator register as base for
// op 0 and peer_key for op 1; a base at or above the prime is reduced first.
// One word takes one modular squaring per exponent bit plus one modular
// multiply per set bit (k multiplies, 64 to 128). The result becomes valid
// in the same cycle that the input reopens. Every multiply runs on the
// single 64-step shift-and-add multiplier (a row of four 16-bit cells).
// One word is processed at a time; a finished result is held in the output
// register and the next word is accepted while it waits.
module dh64_modular_exponentiation (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dh64_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [dh64_pkg::WORD_W-1:0]   s_peer_key,
    input  logic [dh64_pkg::WORD_W-1:0]   s_exponent,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dh64_pkg::WORD_W-1:0]   m_result
);
    localparam int unsigned W = dh64_pkg::WORD_W;

    dh64_pkg::state_t            state_reg, state_next;
    logic [W-1:0]                gen_reg;
    logic [W-1:0]                base_reg, base_next;
    logic [W-1:0]                exp_reg, exp_next;
    logic [dh64_pkg::CNT_W-1:0]  bit_reg, bit_next;
    logic                        m_valid_reg, m_valid_next;
    logic [W-1:0]                result_reg, result_next;
    logic [W-1:0]                base_raw;
    logic                        mul_start, mul_done;
    logic [W-1:0]                mul_a, mul_b, product;
    logic                        accept;

    assign s_ready = state_reg == dh64_pkg::ST_IDLE;
    assign accept  = s_valid & s_ready;
    assign base_raw = (s_op == dh64_pkg::OP_SHARED) ? s_peer_key : gen_reg;

    dh64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (product)
    );

    // square-and-multiply sequencing over the exponent bits
    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        mul_start    = 1'b0;
        mul_a        = product;
        mul_b        = product;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            dh64_pkg::ST_IDLE: begin
                if (accept) begin
                    base_next  = (base_raw >= dh64_pkg::DH_PRIME) ?
                                 base_raw - dh64_pkg::DH_PRIME : base_raw;
                    exp_next   = s_exponent;
                    bit_next   = '1;
                    mul_start  = 1'b1;
                    mul_a      = W'(1);
                    mul_b      = W'(1);
                    state_next = dh64_pkg::ST_SQR;
                end
            end
            dh64_pkg::ST_SQR: begin
                if (mul_done) begin
                    if (exp_reg[W-1]) begin
                        mul_start  = 1'b1;
                        mul_b      = base_reg;
                        state_next = dh64_pkg::ST_MUL;
                    end else if (bit_reg == '0) begin
                        state_next = dh64_pkg::ST_FIN;
                    end else begin
                        mul_start = 1'b1;
                        exp_next  = {exp_reg[W-2:0], 1'b0};
                        bit_next  = bit_reg - 1'b1;
                    end
                end
            end
            dh64_pkg::ST_MUL: begin
                if (mul_done) begin
                    if (bit_reg == '0) begin
                        state_next = dh64_pkg::ST_FIN;
                    end else begin
                        mul_start  = 1'b1;
                        exp_next   = {exp_reg[W-2:0], 1'b0};
                        bit_next   = bit_reg - 1'b1;
                        state_next = dh64_pkg::ST_SQR;
                    end
                end
            end
            dh64_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    result_next  = product;
                    state_next   = dh64_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dh64_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dh64_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            gen_reg     <= dh64_pkg::DH_GEN_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                gen_reg <= cfg_wdata;
            end
        end
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

/* hdl/dh64_cell.sv */
// dh64_cell: one 16-bit slice of the modular shift-and-add multiplier
// depends on dh64_pkg
module dh64_cell (
    input  logic                          aclk,
    input  dh64_pkg::cell_ctl_t           ctl,
    input  logic [dh64_pkg::CELL_W-1:0]   p_slice,
    input  logic [dh64_pkg::CELL_W-1:0]   x_init,
    input  dh64_pkg::cell_link_t          link_in,
    output dh64_pkg::cell_link_t          link_out,
    output logic [dh64_pkg::CELL_W-1:0]   acc
);
    localparam int unsigned W = dh64_pkg::CELL_W;

    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] x_reg, x_next;
    logic [W:0]   sum_a, sum_x, dif_a, dif_x;

    // slice of acc + x and x + x, then minus the prime
    always_comb begin
        sum_a = {1'b0, acc_reg} + {1'b0, x_reg} + {{W{1'b0}}, link_in.ca};
        sum_x = {1'b0, x_reg} + {1'b0, x_reg} + {{W{1'b0}}, link_in.cx};
        dif_a = {1'b0, sum_a[W-1:0]} - {1'b0, p_slice} - {{W{1'b0}}, link_in.ba};
        dif_x = {1'b0, sum_x[W-1:0]} - {1'b0, p_slice} - {{W{1'b0}}, link_in.bx};
        link_out.ca = sum_a[W];
        link_out.cx = sum_x[W];
        link_out.ba = dif_a[W];
        link_out.bx = dif_x[W];
    end

    // next slice values
    always_comb begin
        acc_next = acc_reg;
        x_next   = x_reg;
        if (ctl.load) begin
            acc_next = '0;
            x_next   = x_init;
        end else if (ctl.run) begin
            if (ctl.add_en) begin
                acc_next = ctl.sel_a ? dif_a[W-1:0] : sum_a[W-1:0];
            end
            x_next = ctl.sel_x ? dif_x[W-1:0] : sum_x[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
    end

    assign acc = acc_reg;

endmodule

/* hdl/dh64_mul.sv */
// dh64_mul: modular multiplier built from a row of dh64_cell slices
// depends on dh64_pkg, dh64_cell
module dh64_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dh64_pkg::WORD_W-1:0]   op_a,
    input  logic [dh64_pkg::WORD_W-1:0]   op_b,
    output logic                          done,
    output logic [dh64_pkg::WORD_W-1:0]   product
);
    localparam int unsigned W  = dh64_pkg::WORD_W;
    localparam int unsigned CW = dh64_pkg::CELL_W;
    localparam int unsigned N  = dh64_pkg::NCELLS;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [dh64_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]                y_reg, y_next;
    dh64_pkg::cell_ctl_t         ctl;
    dh64_pkg::cell_link_t        link [N+1];

    assign link[0] = '0;

    // row of cells, carries ripple upward
    for (genvar i = 0; i < N; i++) begin : g_cell
        dh64_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .p_slice  (dh64_pkg::DH_PRIME[i*CW +: CW]),
            .x_init   (op_a[i*CW +: CW]),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .acc      (product[i*CW +: CW])
        );
    end

    // reduce when the sum carried out or did not borrow against the prime
    always_comb begin
        ctl.load   = start;
        ctl.run    = busy_reg;
        ctl.add_en = y_reg[0];
        ctl.sel_a  = link[N].ca | ~link[N].ba;
        ctl.sel_x  = link[N].cx | ~link[N].bx;
    end

    // step counter and multiplier shift register
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        y_next    = y_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            y_next    = op_b;
        end else if (busy_reg) begin
            y_next   = {1'b0, y_reg[W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dh64_pkg::CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        y_reg <= y_next;
    end

    assign done = done_reg;

endmodule

/* hdl/dh64_checker.sv */
// dh64_checker: port-level assertions for dh64_modular_exponentiation
// depends on dh64_pkg; bound to the top level below
module dh64_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dh64_pkg::WORD_W-1:0]   m_result
);
    // no result and the input open right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or busy after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result dropped or changed while stalled");

    // every result is reduced below the prime
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result < dh64_pkg::DH_PRIME)
        else $error("result not reduced");

    // a word in flight keeps the input closed
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened during exponentiation");

endmodule

bind dh64_modular_exponentiation dh64_checker u_dh64_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

/* tb/dh64_modular_exponentiation_check.sv */
// dh64_modular_exponentiation_check: watches both channels, predicts each result word
// depends on dh64_pkg
module dh64_modular_exponentiation_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dh64_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_op,
    input  logic [dh64_pkg::WORD_W-1:0]   s_peer_key,
    input  logic [dh64_pkg::WORD_W-1:0]   s_exponent,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [dh64_pkg::WORD_W-1:0]   m_result,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [dh64_pkg::WORD_W-1:0] gen_reg;
    logic [dh64_pkg::WORD_W-1:0] power_q[$];

    // product mod prime, exact via 128-bit arithmetic
    function automatic logic [dh64_pkg::WORD_W-1:0] mulmod(
        logic [dh64_pkg::WORD_W-1:0] a, logic [dh64_pkg::WORD_W-1:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return dh64_pkg::WORD_W'(p % {64'd0, dh64_pkg::DH_PRIME});
    endfunction

    // left-to-right square-and-multiply
    function automatic logic [dh64_pkg::WORD_W-1:0] modpow(
        logic [dh64_pkg::WORD_W-1:0] b, logic [dh64_pkg::WORD_W-1:0] e);
        logic [dh64_pkg::WORD_W-1:0] acc;
        acc = 64'd1;
        if (b >= dh64_pkg::DH_PRIME) b = b - dh64_pkg::DH_PRIME;
        for (int i = dh64_pkg::WORD_W - 1; i >= 0; i--) begin
            acc = mulmod(acc, acc);
            if (e[i]) acc = mulmod(acc, b);
        end
        return acc;
    endfunction

    assign pending = power_q.size();

    always @(posedge aclk) begin
        logic [dh64_pkg::WORD_W-1:0] want;
        if (!aresetn) begin
            gen_reg <= dh64_pkg::DH_GEN_RESET;
            power_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) gen_reg <= cfg_wdata;
            // predict on accepted input word
            if (s_valid && s_ready)
                power_q.push_back(modpow(s_op == dh64_pkg::OP_SHARED ? s_peer_key : gen_reg,
                                         s_exponent));
            // compare accepted result word
            if (m_valid && m_ready) begin
                if (power_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = power_q.pop_front();
                    if (want !== m_result) begin
                        $display("%0t: result expected %h actual %h", $time, want, m_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/dh64_modular_exponentiation_test.sv */
// dh64_modular_exponentiation_test: stimulus and verdict for the modular power block
// depends on dh64_pkg, dh64_modular_exponentiation, dh64_modular_exponentiation_check
module dh64_modular_exponentiation_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [dh64_pkg::WORD_W-1:0] cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_op = dh64_pkg::OP_PUBLIC;
    logic [dh64_pkg::WORD_W-1:0] s_peer_key = '0;
    logic [dh64_pkg::WORD_W-1:0] s_exponent = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [dh64_pkg::WORD_W-1:0] m_result;
    int                          fail_count;
    int                          pending;
    bit                          feed_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dh64_modular_exponentiation i_dut (.*);
    dh64_modular_exponentiation_check i_check (.*);

    function automatic logic [dh64_pkg::WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // exponents mostly short so the run stays fast, some full width
    function automatic logic [dh64_pkg::WORD_W-1:0] rand_exp();
        case ($urandom_range(0, 3))
            0: return rand64();
            1: return rand64() >> $urandom_range(0, 63);
            default: return rand64() >> $urandom_range(40, 63);
        endcase
    endfunction

    task automatic send_word(logic op, logic [dh64_pkg::WORD_W-1:0] key,
                             logic [dh64_pkg::WORD_W-1:0] ex);
        repeat ($urandom_range(0, 4)) @(posedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_peer_key <= key;
        s_exponent <= ex;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic write_gen(logic [dh64_pkg::WORD_W-1:0] g);
        while (pending != 0) @(posedge aclk);
        repeat (8400) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // result side stalls at random
    initial begin
        @(posedge aresetn);
        forever begin
            m_ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [dh64_pkg::WORD_W-1:0] gens[4];
        gens = '{64'd1, dh64_pkg::DH_PRIME - 1, 64'd2, 64'd3};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: reset generator, extremes, base reduction, zero cases
        send_word(dh64_pkg::OP_PUBLIC, 64'hffff_ffff_ffff_ffff, 64'd0);
        send_word(dh64_pkg::OP_PUBLIC, 64'd0, 64'd1);
        send_word(dh64_pkg::OP_PUBLIC, 64'd0, 64'hffff_ffff_ffff_ffff);
        send_word(dh64_pkg::OP_SHARED, 64'd0, 64'd0);
        send_word(dh64_pkg::OP_SHARED, 64'd0, 64'd7);
        send_word(dh64_pkg::OP_SHARED, dh64_pkg::DH_PRIME, 64'd3);
        send_word(dh64_pkg::OP_SHARED, dh64_pkg::DH_PRIME + 1, 64'd5);
        send_word(dh64_pkg::OP_SHARED, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_word(dh64_pkg::OP_SHARED, dh64_pkg::DH_PRIME - 1, 64'd2);
        send_word(dh64_pkg::OP_SHARED, 64'd2, 64'h8000_0000_0000_0000);
        send_word(dh64_pkg::OP_SHARED, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        // random phases, each under a different generator
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0)
                write_gen(ph == 4 ? rand64() % (dh64_pkg::DH_PRIME - 1) + 1 : gens[ph - 1]);
            for (int n = 0; n < 18; n++) begin
                send_word($urandom_range(0, 1) ? dh64_pkg::OP_SHARED : dh64_pkg::OP_PUBLIC,
                          rand64(), rand_exp());
            end
        end
        feed_done = 1'b1;
    end

    // verdict, after the last word so its prediction is queued
    initial begin
        wait (feed_done);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS dh64_modular_exponentiation");
        end else begin
            $display("FAIL dh64_modular_exponentiation");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL dh64_modular_exponentiation");
        $finish;
    end
endmodule

/* files.f */
hdl/dh64_pkg.sv
hdl/dh64_cell.sv
hdl/dh64_mul.sv
hdl/dh64_modular_exponentiation.sv
hdl/dh64_checker.sv
tb/dh64_modular_exponentiation_check.sv
tb/dh64_modular_exponentiation_test.sv
